[design/assert_macros.svh]
// Assertion macros shared by the design files.
// With SYNTH defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");

// Consequent must hold at the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/wcse_pkg.sv]
package wcse_pkg;

	// Operation codes carried by an input transaction.
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_ENTER = 3'd3;
	localparam logic [2:0] OP_LOAD  = 3'd4;

	// Session modes.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_RUN  = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
	localparam logic [1:0] CFG_SLOW_ENERGY_STEP = 2'd1;
	localparam logic [1:0] CFG_FAST_ENERGY_STEP = 2'd2;
	localparam logic [1:0] CFG_SLOW_SPEED_LIMIT = 2'd3;

	// Configuration reset values.
	localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd250;
	localparam logic [9:0] SLOW_ENERGY_STEP_RST = 10'd105;
	localparam logic [9:0] FAST_ENERGY_STEP_RST = 10'd140;
	localparam logic [5:0] SLOW_SPEED_LIMIT_RST = 6'd15;

	// Time-keeping limits.
	localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
	localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
	localparam logic [4:0] HOUR_MAX           = 5'd23;
	localparam logic [5:0] MINUTE_MAX         = 6'd59;
	localparam logic [5:0] SECOND_MAX         = 6'd59;

	// A zero tick register means a full wrap of the 8-bit counter.
	localparam logic [8:0] TICK_FULL_WRAP = 9'd256;

	localparam logic [23:0] ENERGY_MAX = 24'hFF_FFFF;

	typedef struct packed {
		logic [2:0] operation;
		logic [5:0] speed;
		logic [4:0] load_hour;
		logic [5:0] load_minute;
		logic [5:0] load_second;
	} item_t;

	typedef struct packed {
		logic [4:0]  clock_hour;
		logic [5:0]  clock_minute;
		logic [5:0]  clock_second;
		logic [4:0]  session_hour;
		logic [5:0]  session_minute;
		logic [5:0]  session_second;
		logic [23:0] energy_milli_kcal;
		logic [1:0]  run_mode;
	} result_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

endpackage

[design/workout_clock_stopwatch_energy.sv]
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------
// item      | item_valid / item_ready    | wcse_pkg::item_t
// result    | result_valid / result_ready| wcse_pkg::result_t
// cfg       | cfg_we (no wait)           | cfg_index, cfg_data
//
// Each accepted transaction is held in the input register and then produces
// exactly one result in the result register, so a transaction passes the
// input register and then the result register before it is presented, and
// one transaction can be accepted in every cycle unless the result stalls.
// The rate is set by the update of the clock, stopwatch and energy
// registers, which sits between the input and result registers.
// arst_n clears all control and time-keeping state and restores the
// configuration reset values. A stalled result holds the result register and
// the input register, and item_ready falls only when both are occupied.
`include "assert_macros.svh"

module workout_clock_stopwatch_energy (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  wcse_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output wcse_pkg::result_t   result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [9:0]          cfg_data
);

	import wcse_pkg::*;

	// Step a time of day by one second with 60/60/24 rollover.
	function automatic hms_t next_second(hms_t t);
		hms_t        r;
		logic [5:0]  sec_inc;
		logic [5:0]  min_inc;
		logic [4:0]  hour_inc;
		r        = t;
		sec_inc  = t.second + 6'd1;
		min_inc  = t.minute + 6'd1;
		hour_inc = t.hour + 5'd1;
		if (sec_inc >= SECONDS_PER_MINUTE) begin
			r.second = '0;
			if (min_inc >= MINUTES_PER_HOUR) begin
				r.minute = '0;
				r.hour   = (hour_inc >= HOURS_PER_DAY) ? 5'd0 : hour_inc;
			end else begin
				r.minute = min_inc;
			end
		end else begin
			r.second = sec_inc;
		end
		return r;
	endfunction

	// Configuration registers.
	logic [7:0] ticks_per_second_q;
	logic [9:0] slow_energy_step_q;
	logic [9:0] fast_energy_step_q;
	logic [5:0] slow_speed_limit_q;

	// Input register.
	logic  valid_s1;
	item_t item_s1;

	// Architectural state.
	logic [7:0]  clock_tick_q;
	hms_t        clock_time_q;
	logic [7:0]  session_tick_q;
	hms_t        session_time_q;
	logic [23:0] energy_q;
	logic [1:0]  mode_q;

	// Result register.
	logic    result_valid_q;
	result_t result_q;

	// Next-state logic.
	logic        advance;
	logic        update;
	logic [8:0]  tick_limit;
	logic [8:0]  clock_tick_inc;
	logic [8:0]  session_tick_inc;
	logic        clock_wrap;
	logic        session_wrap;
	logic        slow_speed;
	logic [9:0]  energy_step;
	logic [24:0] energy_sum;
	logic [7:0]  clock_tick_d;
	hms_t        clock_time_d;
	logic [7:0]  session_tick_d;
	hms_t        session_time_d;
	logic [23:0] energy_d;
	logic [1:0]  mode_d;

	// The result register moves on when empty or when its transaction is taken;
	// the input register then hands its transaction over in the same edge.
	assign advance    = !result_valid_q || result_ready;
	assign update     = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_second_q <= TICKS_PER_SECOND_RST;
			slow_energy_step_q <= SLOW_ENERGY_STEP_RST;
			fast_energy_step_q <= FAST_ENERGY_STEP_RST;
			slow_speed_limit_q <= SLOW_SPEED_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICKS_PER_SECOND: ticks_per_second_q <= cfg_data[7:0];
				CFG_SLOW_ENERGY_STEP: slow_energy_step_q <= cfg_data;
				CFG_FAST_ENERGY_STEP: fast_energy_step_q <= cfg_data;
				CFG_SLOW_SPEED_LIMIT: slow_speed_limit_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// A zero tick register counts a full wrap of the 8-bit tick counter.
	assign tick_limit       = (ticks_per_second_q == 8'd0) ? TICK_FULL_WRAP
	                          : {1'b0, ticks_per_second_q};
	assign clock_tick_inc   = {1'b0, clock_tick_q} + 9'd1;
	assign session_tick_inc = {1'b0, session_tick_q} + 9'd1;
	assign clock_wrap       = clock_tick_inc >= tick_limit;
	assign session_wrap     = session_tick_inc >= tick_limit;

	// Standing still counts as fast, as does any speed at or above the limit.
	assign slow_speed  = (item_s1.speed != 6'd0) && (item_s1.speed < slow_speed_limit_q);
	assign energy_step = slow_speed ? slow_energy_step_q : fast_energy_step_q;
	assign energy_sum  = {1'b0, energy_q} + {15'd0, energy_step};

	always_comb begin
		clock_tick_d   = clock_tick_q;
		clock_time_d   = clock_time_q;
		session_tick_d = session_tick_q;
		session_time_d = session_time_q;
		energy_d       = energy_q;
		mode_d         = mode_q;
		case (item_s1.operation)
			OP_TICK: begin
				clock_tick_d = clock_wrap ? 8'd0 : clock_tick_inc[7:0];
				if (clock_wrap) begin
					clock_time_d = next_second(clock_time_q);
				end
				if (mode_q == MODE_RUN) begin
					session_tick_d = session_wrap ? 8'd0 : session_tick_inc[7:0];
					if (session_wrap) begin
						session_time_d = next_second(session_time_q);
						energy_d       = energy_sum[24] ? ENERGY_MAX : energy_sum[23:0];
					end
				end
			end
			OP_START: begin
				if (mode_q == MODE_IDLE) begin
					session_tick_d = '0;
					session_time_d = '0;
					energy_d       = '0;
					mode_d         = MODE_RUN;
				end
			end
			OP_STOP: begin
				if (mode_q == MODE_RUN) begin
					mode_d = MODE_STOP;
				end
			end
			OP_ENTER: begin
				if (mode_q == MODE_STOP) begin
					mode_d = MODE_IDLE;
				end
			end
			OP_LOAD: begin
				// Out-of-range fields are clamped, and a fresh second begins.
				clock_time_d.hour   = (item_s1.load_hour > HOUR_MAX) ? HOUR_MAX
				                      : item_s1.load_hour;
				clock_time_d.minute = (item_s1.load_minute > MINUTE_MAX) ? MINUTE_MAX
				                      : item_s1.load_minute;
				clock_time_d.second = (item_s1.load_second > SECOND_MAX) ? SECOND_MAX
				                      : item_s1.load_second;
				clock_tick_d        = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_tick_q   <= '0;
			clock_time_q   <= '0;
			session_tick_q <= '0;
			session_time_q <= '0;
			energy_q       <= '0;
			mode_q         <= MODE_IDLE;
		end else if (update) begin
			clock_tick_q   <= clock_tick_d;
			clock_time_q   <= clock_time_d;
			session_tick_q <= session_tick_d;
			session_time_q <= session_time_d;
			energy_q       <= energy_d;
			mode_q         <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			result_q.clock_hour        <= clock_time_d.hour;
			result_q.clock_minute      <= clock_time_d.minute;
			result_q.clock_second      <= clock_time_d.second;
			result_q.session_hour      <= session_time_d.hour;
			result_q.session_minute    <= session_time_d.minute;
			result_q.session_second    <= session_time_d.second;
			result_q.energy_milli_kcal <= energy_d;
			result_q.run_mode          <= mode_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Every transaction that leaves the input register shows up as a result.
	`ASSERT_NEXT(a_update_gives_result, clk, arst_n, update, result_valid_q)

	// The time of day never leaves its legal range.
	`ASSERT_ALWAYS(a_clock_in_range, clk, arst_n,
		(clock_time_q.second < SECONDS_PER_MINUTE) && (clock_time_q.minute < MINUTES_PER_HOUR)
		&& (clock_time_q.hour < HOURS_PER_DAY))

	// Energy only falls when a start from idle clears the session.
	`ASSERT_NEXT(a_energy_monotonic, clk, arst_n,
		!(update && (item_s1.operation == OP_START) && (mode_q == MODE_IDLE)),
		energy_q >= $past(energy_q))

	// A stopped session is frozen until it returns to idle.
	`ASSERT_NEXT(a_stopped_frozen, clk, arst_n, mode_q == MODE_STOP,
		$stable(session_time_q) && $stable(energy_q))

endmodule

[sim/workout_clock_stopwatch_energy_tb.sv]
`timescale 1ns / 100ps

module workout_clock_stopwatch_energy_tb;
	import wcse_pkg::*;

	// The three operation codes that the block has no use for. They must leave every
	// piece of state alone and still return a readout.
	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;

	localparam result_t NO_READOUT = '0;

	// One line of the directed table. Where typed is set, want holds the readout as it
	// can be read off by hand. Otherwise the readout comes from the local model.
	typedef struct {
		item_t   stim;
		bit      typed;
		result_t want;
	} directed_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	logic    cfg_we;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;

	// Our own copy of the configuration registers.
	logic [7:0] tps_q;
	logic [9:0] slow_step_q;
	logic [9:0] fast_step_q;
	logic [5:0] slow_limit_q;

	// Our own copy of the time-keeping state.
	logic [7:0]  wall_ticks;
	logic [7:0]  lap_ticks;
	hms_t        wall_time;
	hms_t        lap_time;
	logic [23:0] energy_acc;
	logic [1:0]  mode_q;

	// Readouts that are owed by the block, oldest first.
	result_t     due_readouts[$];
	int unsigned mismatches = 0;
	// While calm is set neither side inserts idle cycles.
	bit          calm = 1'b0;

	// The directed part, run with one second per tick, the slow step at its maximum,
	// the fast step at zero and the speed limit at its maximum. Tick rows carry
	// saturated load fields so that we can see that they are ignored.
	directed_row_t directed_rows [25] = '{
		// Keys that have no effect straight after reset.
		'{'{OP_STOP,  6'd0,  5'd0,  6'd0,  6'd0},  1'b1,
			'{5'd0,  6'd0,  6'd0,  5'd0, 6'd0, 6'd0, 24'd0, MODE_IDLE}},
		'{'{OP_ENTER, 6'd0,  5'd0,  6'd0,  6'd0},  1'b1,
			'{5'd0,  6'd0,  6'd0,  5'd0, 6'd0, 6'd0, 24'd0, MODE_IDLE}},
		// The last second of the day, then a tick that rolls every field over.
		'{'{OP_LOAD,  6'd63, 5'd23, 6'd59, 6'd59}, 1'b1,
			'{5'd23, 6'd59, 6'd59, 5'd0, 6'd0, 6'd0, 24'd0, MODE_IDLE}},
		'{'{OP_TICK,  6'd0,  5'd31, 6'd63, 6'd63}, 1'b1,
			'{5'd0,  6'd0,  6'd0,  5'd0, 6'd0, 6'd0, 24'd0, MODE_IDLE}},
		// An out-of-range load saturates each field on its own.
		'{'{OP_LOAD,  6'd0,  5'd31, 6'd63, 6'd63}, 1'b1,
			'{5'd23, 6'd59, 6'd59, 5'd0, 6'd0, 6'd0, 24'd0, MODE_IDLE}},
		'{'{OP_LOAD,  6'd0,  5'd0,  6'd0,  6'd0},  1'b1,
			'{5'd0,  6'd0,  6'd0,  5'd0, 6'd0, 6'd0, 24'd0, MODE_IDLE}},
		'{'{OP_START, 6'd63, 5'd31, 6'd63, 6'd63}, 1'b1,
			'{5'd0,  6'd0,  6'd0,  5'd0, 6'd0, 6'd0, 24'd0, MODE_RUN}},
		// Speed zero takes the fast step, which is zero here; speed one takes the slow one.
		'{'{OP_TICK,  6'd0,  5'd31, 6'd63, 6'd63}, 1'b1,
			'{5'd0,  6'd0,  6'd1,  5'd0, 6'd0, 6'd1, 24'd0, MODE_RUN}},
		'{'{OP_TICK,  6'd1,  5'd31, 6'd63, 6'd63}, 1'b1,
			'{5'd0,  6'd0,  6'd2,  5'd0, 6'd0, 6'd2, 24'd1023, MODE_RUN}},
		// Either side of the speed limit.
		'{'{OP_TICK,  6'd62, 5'd31, 6'd63, 6'd63}, 1'b0, NO_READOUT},
		'{'{OP_TICK,  6'd63, 5'd31, 6'd63, 6'd63}, 1'b0, NO_READOUT},
		// Keys that mean nothing while running, and the spare codes.
		'{'{OP_START, 6'd0,  5'd0,  6'd0,  6'd0},  1'b0, NO_READOUT},
		'{'{OP_ENTER, 6'd0,  5'd0,  6'd0,  6'd0},  1'b0, NO_READOUT},
		'{'{OP_SPARE_LO,  6'd63, 5'd31, 6'd63, 6'd63}, 1'b0, NO_READOUT},
		'{'{OP_SPARE_MID, 6'd20, 5'd10, 6'd20, 6'd30}, 1'b0, NO_READOUT},
		'{'{OP_SPARE_HI,  6'd0,  5'd23, 6'd59, 6'd59}, 1'b0, NO_READOUT},
		// Stopped: the clock keeps going while the stopwatch is frozen.
		'{'{OP_STOP,  6'd0,  5'd0,  6'd0,  6'd0},  1'b0, NO_READOUT},
		'{'{OP_TICK,  6'd5,  5'd31, 6'd63, 6'd63}, 1'b0, NO_READOUT},
		'{'{OP_START, 6'd0,  5'd0,  6'd0,  6'd0},  1'b0, NO_READOUT},
		'{'{OP_STOP,  6'd0,  5'd0,  6'd0,  6'd0},  1'b0, NO_READOUT},
		'{'{OP_ENTER, 6'd0,  5'd0,  6'd0,  6'd0},  1'b0, NO_READOUT},
		// Back in idle, a tick and then a fresh session that clears the stopwatch.
		'{'{OP_TICK,  6'd10, 5'd31, 6'd63, 6'd63}, 1'b0, NO_READOUT},
		'{'{OP_START, 6'd0,  5'd0,  6'd0,  6'd0},  1'b0, NO_READOUT},
		'{'{OP_LOAD,  6'd21, 5'd12, 6'd34, 6'd56}, 1'b0, NO_READOUT},
		'{'{OP_TICK,  6'd40, 5'd31, 6'd63, 6'd63}, 1'b0, NO_READOUT}
	};

	workout_clock_stopwatch_energy i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Counts one tick into a tick counter and reports whether it has made a second.
	// A zero register stands for a full wrap of the 8-bit counter, and the test is
	// greater-or-equal, so lowering the register below the count ends the second on
	// the very next tick.
	function automatic bit tick_makes_second(inout logic [7:0] count);
		int span;
		int nxt;
		span = (tps_q == 8'd0) ? int'(TICK_FULL_WRAP) : int'(tps_q);
		nxt = int'(count) + 1;
		if (nxt >= span) begin
			count = '0;
			return 1'b1;
		end
		count = 8'(nxt);
		return 1'b0;
	endfunction

	// HH:MM:SS moved on by one second, wrapping at 60, 60 and 24.
	function automatic hms_t one_second_on(hms_t t);
		hms_t n;
		n = t;
		if (n.second >= SECOND_MAX) begin
			n.second = '0;
			if (n.minute >= MINUTE_MAX) begin
				n.minute = '0;
				n.hour = (n.hour >= HOUR_MAX) ? 5'd0 : n.hour + 5'd1;
			end else begin
				n.minute = n.minute + 6'd1;
			end
		end else begin
			n.second = n.second + 6'd1;
		end
		return n;
	endfunction

	// Applies one event to our copy of the state and returns the readout that the
	// block should show afterwards.
	function automatic result_t apply_event(item_t ev);
		logic [24:0] sum;
		logic [9:0]  step;
		result_t     r;
		case (ev.operation)
			OP_TICK: begin
				if (tick_makes_second(wall_ticks))
					wall_time = one_second_on(wall_time);
				// The stopwatch tick counter only moves in run mode.
				if (mode_q == MODE_RUN) begin
					if (tick_makes_second(lap_ticks)) begin
						lap_time = one_second_on(lap_time);
						if (ev.speed != 6'd0 && ev.speed < slow_limit_q)
							step = slow_step_q;
						else
							step = fast_step_q;
						sum = {1'b0, energy_acc} + 25'(step);
						energy_acc = (sum > 25'(ENERGY_MAX)) ? ENERGY_MAX : sum[23:0];
					end
				end
			end
			OP_START: begin
				if (mode_q == MODE_IDLE) begin
					lap_time = '0;
					lap_ticks = '0;
					energy_acc = '0;
					mode_q = MODE_RUN;
				end
			end
			OP_STOP: begin
				if (mode_q == MODE_RUN)
					mode_q = MODE_STOP;
			end
			OP_ENTER: begin
				if (mode_q == MODE_STOP)
					mode_q = MODE_IDLE;
			end
			OP_LOAD: begin
				wall_time.hour = (ev.load_hour > HOUR_MAX) ? HOUR_MAX : ev.load_hour;
				wall_time.minute = (ev.load_minute > MINUTE_MAX) ? MINUTE_MAX : ev.load_minute;
				wall_time.second = (ev.load_second > SECOND_MAX) ? SECOND_MAX : ev.load_second;
				wall_ticks = '0;
			end
			default: begin
			end
		endcase
		r.clock_hour = wall_time.hour;
		r.clock_minute = wall_time.minute;
		r.clock_second = wall_time.second;
		r.session_hour = lap_time.hour;
		r.session_minute = lap_time.minute;
		r.session_second = lap_time.second;
		r.energy_milli_kcal = energy_acc;
		r.run_mode = mode_q;
		return r;
	endfunction

	// Length of an idle stretch: mostly none, often short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Offers one event and waits for its transaction. valid is only lowered when a gap
	// is wanted, so back-to-back events keep it high without a glitch.
	task automatic offer_event(input item_t ev, input bit typed, input result_t want);
		int      gap;
		result_t predicted;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= ev;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		// The model always runs so that its state stays in step with the block.
		predicted = apply_event(ev);
		due_readouts.push_back(typed ? want : predicted);
	endtask

	// Writes all four registers once the block has drained. Data bits above a
	// register's width are sent as given and must be dropped by the block.
	task automatic write_regs(input logic [9:0] tps, slow, fast, limit);
		item_valid <= 1'b0;
		while (due_readouts.size() != 0) @(posedge clk);
		// Spare cycles so that the last result has left the output register.
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TICKS_PER_SECOND;
		cfg_data <= tps;
		@(posedge clk);
		cfg_index <= CFG_SLOW_ENERGY_STEP;
		cfg_data <= slow;
		@(posedge clk);
		cfg_index <= CFG_FAST_ENERGY_STEP;
		cfg_data <= fast;
		@(posedge clk);
		cfg_index <= CFG_SLOW_SPEED_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		tps_q = tps[7:0];
		slow_step_q = slow;
		fast_step_q = fast;
		slow_limit_q = limit[5:0];
	endtask

	// Random events. tick_pct sets the share of ticks; the rest are keys, loads and
	// the odd spare code. Speeds cluster on zero, one, either side of the limit and
	// the maximum, and load fields are drawn from their full width about one time in four.
	task automatic random_events(input int count, input int tick_pct);
		item_t ev;
		int    r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < tick_pct) begin
				ev.operation = OP_TICK;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 20)
					ev.operation = OP_START;
				else if (r < 40)
					ev.operation = OP_STOP;
				else if (r < 60)
					ev.operation = OP_ENTER;
				else if (r < 85)
					ev.operation = OP_LOAD;
				else
					ev.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			end
			case ($urandom_range(0, 9))
				0: ev.speed = 6'd0;
				1: ev.speed = 6'd1;
				2: ev.speed = slow_limit_q - 6'd1;
				3: ev.speed = slow_limit_q;
				4: ev.speed = 6'd63;
				default: ev.speed = 6'($urandom_range(0, 63));
			endcase
			if ($urandom_range(0, 3) == 0) begin
				ev.load_hour = 5'($urandom_range(0, 31));
				ev.load_minute = 6'($urandom_range(0, 63));
				ev.load_second = 6'($urandom_range(0, 63));
			end else begin
				ev.load_hour = 5'($urandom_range(0, 23));
				ev.load_minute = 6'($urandom_range(0, 59));
				ev.load_second = 6'($urandom_range(0, 59));
			end
			offer_event(ev, 1'b0, NO_READOUT);
		end
	endtask

	task automatic field_check(input string name, input logic [23:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Sender side: reset, the directed table, several random phases under different
	// register settings, and finally a short session at the largest steps.
	initial begin : event_side
		item_t ev;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TICKS_PER_SECOND;
		cfg_data = '0;
		tps_q = TICKS_PER_SECOND_RST;
		slow_step_q = SLOW_ENERGY_STEP_RST;
		fast_step_q = FAST_ENERGY_STEP_RST;
		slow_limit_q = SLOW_SPEED_LIMIT_RST;
		wall_ticks = '0;
		lap_ticks = '0;
		wall_time = '0;
		lap_time = '0;
		energy_acc = '0;
		mode_q = MODE_IDLE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// One tick per second, slow step at its maximum, fast step zero, top speed limit.
		write_regs(10'd1, 10'd1023, 10'd0, 10'd63);
		foreach (directed_rows[i])
			offer_event(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

		// Two ticks per second, and a limit of one so that no speed is slow. The
		// upper data bits are set so that truncation to the register width is seen.
		write_regs(10'h302, 10'd1, 10'd1023, 10'h3C1);
		random_events(60, 70);

		// A zero tick register means 256 ticks per second, and a zero limit means the
		// fast step everywhere. Nearly all ticks so that the counter wraps at least once.
		write_regs(10'h300, 10'd1023, 10'd0, 10'h0C0);
		random_events(300, 95);

		// Three ticks per second may be below the count left behind, and then the
		// first tick here completes a second. No idling in this phase.
		write_regs(10'd3, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
			10'($urandom_range(1, 63)));
		calm = 1'b1;
		random_events(60, 70);
		calm = 1'b0;

		write_regs(10'd255, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
			10'($urandom_range(0, 63)));
		random_events(50, 70);

		write_regs(10'd1, 10'(SLOW_ENERGY_STEP_RST), 10'(FAST_ENERGY_STEP_RST),
			10'(SLOW_SPEED_LIMIT_RST));
		random_events(50, 70);

		write_regs(10'(TICKS_PER_SECOND_RST), 10'(SLOW_ENERGY_STEP_RST),
			10'(FAST_ENERGY_STEP_RST), 10'(SLOW_SPEED_LIMIT_RST));
		random_events(30, 70);

		// A short session at one tick per second and the largest steps. Stop, enter
		// and start bring any mode to a fresh run.
		write_regs(10'd1, 10'd1023, 10'd1023, 10'd15);
		calm = 1'b1;
		ev = '0;
		ev.operation = OP_STOP;
		offer_event(ev, 1'b0, NO_READOUT);
		ev.operation = OP_ENTER;
		offer_event(ev, 1'b0, NO_READOUT);
		ev.operation = OP_START;
		offer_event(ev, 1'b0, NO_READOUT);
		ev.operation = OP_TICK;
		repeat (10) begin
			ev.speed = 6'($urandom_range(0, 63));
			offer_event(ev, 1'b0, NO_READOUT);
		end

		item_valid <= 1'b0;
		while (due_readouts.size() != 0) @(posedge clk);
		// Any stray result would turn up while the input and result registers drain.
		repeat (6) @(posedge clk);
		if (mismatches == 0 && due_readouts.size() == 0)
			$display("workout_clock_stopwatch_energy_tb: done, clean");
		else
			$display("workout_clock_stopwatch_energy_tb: done, errors");
		$finish;
	end

	// Receiver side: checks every result transaction against the oldest readout owed,
	// and throttles result_ready. After the 200th result it holds off for a stall
	// so that the block fills up and has to drop item_ready.
	initial begin : readout_side
		int      stall_left;
		int      seen;
		result_t want;
		result_ready = 1'b0;
		stall_left = 0;
		seen = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				seen++;
				if (due_readouts.size() == 0) begin
					$error("result transaction with no readout expected");
					mismatches++;
				end else begin
					want = due_readouts.pop_front();
					field_check("clock_hour", want.clock_hour, result.clock_hour);
					field_check("clock_minute", want.clock_minute, result.clock_minute);
					field_check("clock_second", want.clock_second, result.clock_second);
					field_check("session_hour", want.session_hour, result.session_hour);
					field_check("session_minute", want.session_minute, result.session_minute);
					field_check("session_second", want.session_second, result.session_second);
					field_check("energy_milli_kcal", want.energy_milli_kcal,
						result.energy_milli_kcal);
					field_check("run_mode", want.run_mode, result.run_mode);
				end
				if (seen == 200)
					stall_left = 64;
			end
			if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
				stall_left = idle_len();
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Even with the longest gaps and stalls on every transaction a correct run stays
	// under half a millisecond; anything past 5 ms is a hang.
	initial begin
		#5ms;
		$display("workout_clock_stopwatch_energy_tb: done, errors");
		$finish;
	end

endmodule
